// ===== hw/rtl/lkc_pkg.sv =====
// shared types and constants for the keyed lfu cache table
package lkc_pkg;

  localparam int ENTRIES_DEF    = 8;
  localparam int COUNT_BITS_DEF = 16;
  localparam int KEY_W          = 32;
  localparam int OCC_W          = 4;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } lkc_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN,
    ST_APPLY
  } lkc_state_t;

  // stored words of one entry, the use counter travels beside it
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] tag;
    logic [KEY_W-1:0] handle;
  } lkc_entry_t;

  typedef struct packed {
    logic load;   // take the new entry from the probe registers
    logic shift;  // take the neighbor's entry (close the gap after eviction)
    logic bump;   // saturating increment of the use counter
  } lkc_cell_ctrl_t;

endpackage

// ===== hw/rtl/lkc_if.sv =====
// request and response channel interfaces of the keyed lfu cache table
interface lkc_req_if;
  logic                     valid;
  logic                     ready;
  lkc_pkg::lkc_cmd_t        command;
  logic [lkc_pkg::KEY_W-1:0] state_key;
  logic [lkc_pkg::KEY_W-1:0] pass_tag;
  logic [lkc_pkg::KEY_W-1:0] entry_handle;

  modport source (output valid, command, state_key, pass_tag, entry_handle, input ready);
  modport sink (input valid, command, state_key, pass_tag, entry_handle, output ready);
endinterface

interface lkc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [lkc_pkg::KEY_W-1:0] found_handle;
  logic                      evicted;
  logic [lkc_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, hit, found_handle, evicted, occupancy, input ready);
  modport sink (input valid, hit, found_handle, evicted, occupancy, output ready);
endinterface

// ===== hw/rtl/lkc_cell.sv =====
// one cache cell: entry storage, key compare and counter update
module lkc_cell #(
  parameter int COUNT_BITS = lkc_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic [lkc_pkg::KEY_W-1:0] probe_key,
  input  logic [lkc_pkg::KEY_W-1:0] probe_tag,
  input  logic [lkc_pkg::KEY_W-1:0] probe_handle,
  input  lkc_pkg::lkc_cell_ctrl_t   ctrl,
  input  lkc_pkg::lkc_entry_t       nbr_entry,
  input  logic [COUNT_BITS-1:0]     nbr_count,
  output lkc_pkg::lkc_entry_t       entry,
  output logic [COUNT_BITS-1:0]     count,
  output logic                      match
);

  assign match = (entry.key == probe_key) && (entry.tag == probe_tag);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry.key    <= probe_key;
      entry.tag    <= probe_tag;
      entry.handle <= probe_handle;
      count        <= '0;
    end else if (ctrl.shift) begin
      entry <= nbr_entry;
      count <= nbr_count;
    end else if (ctrl.bump && (count != {COUNT_BITS{1'b1}})) begin
      count <= count + COUNT_BITS'(1);
    end
  end

endmodule

// ===== hw/rtl/lfu_keyed_cache_table.sv =====
// Keyed lfu cache table: a row of ENTRIES cells, each holding state key, pass tag, handle
// and a saturating use counter, packed in insertion order. Every cell compares the probe
// keys in parallel. A request passes a match state, then an update state that also registers
// the response, and a new request is taken in the update state, so the table accepts the next
// request while finishing the last. An insert that misses on a full table adds a scan state: a shared comparator
// walks the cell counters one per cycle to find the first least used entry, after which the
// cells above it shift down one place toward their neighbor and the new entry lands in the
// last cell. A finished response sits in an output register until taken; the next
// request's update waits while that register is still full.
module lfu_keyed_cache_table #(
  parameter int ENTRIES    = lkc_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lkc_pkg::COUNT_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  lkc_req_if.sink   req,
  lkc_rsp_if.source rsp
);

  localparam int IW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);

  lkc_pkg::lkc_state_t state, state_next;

  logic [FW-1:0]             fill_level;
  lkc_pkg::lkc_cmd_t         probe_cmd;
  logic [lkc_pkg::KEY_W-1:0] probe_key;
  logic [lkc_pkg::KEY_W-1:0] probe_tag;
  logic [lkc_pkg::KEY_W-1:0] probe_handle;
  logic [ENTRIES-1:0]        match_r;
  logic                      hit_r;
  logic [IW-1:0]             scan_idx;
  logic [IW-1:0]             victim;
  logic [COUNT_BITS-1:0]     min_count;

  logic                      out_valid;
  logic                      out_hit;
  logic [lkc_pkg::KEY_W-1:0] out_handle;
  logic                      out_evicted;
  logic [lkc_pkg::OCC_W-1:0] out_occ;

  lkc_pkg::lkc_entry_t     entries [ENTRIES];
  logic [COUNT_BITS-1:0]   counts [ENTRIES];
  lkc_pkg::lkc_cell_ctrl_t ctrls [ENTRIES];
  logic [ENTRIES-1:0]      match_raw;
  logic [ENTRIES-1:0]      match_vec;

  logic                      full;
  logic                      out_free;
  logic                      apply_go;
  logic                      accept;
  logic                      need_evict;
  logic                      do_evict;
  logic [IW-1:0]             ins_pos;
  logic [lkc_pkg::KEY_W-1:0] found_handle;
  logic [FW-1:0]             fill_after;

  assign full     = (fill_level == FW'(ENTRIES));
  assign out_free = !out_valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign ins_pos  = full ? IW'(ENTRIES - 1) : fill_level[IW-1:0];

  // cell row: each cell reloads from its upper neighbor when the gap closes
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkc_pkg::lkc_entry_t   nbr_entry;
    logic [COUNT_BITS-1:0] nbr_count;
    if (i < ENTRIES - 1) begin : g_nbr
      assign nbr_entry = entries[i+1];
      assign nbr_count = counts[i+1];
    end else begin : g_top
      assign nbr_entry = entries[i];
      assign nbr_count = counts[i];
    end

    lkc_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk          (clk),
      .probe_key    (probe_key),
      .probe_tag    (probe_tag),
      .probe_handle (probe_handle),
      .ctrl         (ctrls[i]),
      .nbr_entry    (nbr_entry),
      .nbr_count    (nbr_count),
      .entry        (entries[i]),
      .count        (counts[i]),
      .match        (match_raw[i])
    );

    assign match_vec[i] = match_raw[i] && (fill_level > FW'(i));
  end

  assign need_evict = !(|match_vec) && (probe_cmd == lkc_pkg::CMD_INSERT) && full;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lkc_pkg::ST_IDLE: begin
        if (req.valid) state_next = lkc_pkg::ST_MATCH;
      end
      lkc_pkg::ST_MATCH: begin
        state_next = need_evict ? lkc_pkg::ST_SCAN : lkc_pkg::ST_APPLY;
      end
      lkc_pkg::ST_SCAN: begin
        if (scan_idx == IW'(ENTRIES - 1)) state_next = lkc_pkg::ST_APPLY;
      end
      lkc_pkg::ST_APPLY: begin
        if (out_free) state_next = req.valid ? lkc_pkg::ST_MATCH : lkc_pkg::ST_IDLE;
      end
      default: state_next = lkc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    req.ready = 1'b0;
    apply_go  = 1'b0;
    unique case (state)
      lkc_pkg::ST_IDLE:  req.ready = 1'b1;
      lkc_pkg::ST_MATCH: req.ready = 1'b0;
      lkc_pkg::ST_SCAN:  req.ready = 1'b0;
      lkc_pkg::ST_APPLY: begin
        apply_go  = out_free;
        req.ready = out_free;
      end
      default: req.ready = 1'b0;
    endcase
  end

  assign do_evict = apply_go && !hit_r && (probe_cmd == lkc_pkg::CMD_INSERT) && full;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ctrls[i].load  = apply_go && !hit_r && (probe_cmd == lkc_pkg::CMD_INSERT)
                       && (ins_pos == IW'(i));
      ctrls[i].shift = do_evict && (i < ENTRIES - 1) && (victim <= IW'(i));
      ctrls[i].bump  = apply_go && hit_r && (probe_cmd == lkc_pkg::CMD_LOOKUP)
                       && match_r[i];
    end
  end

  always_comb begin
    found_handle = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) found_handle = found_handle | entries[i].handle;
    end
  end

  always_comb begin
    fill_after = fill_level;
    if (!hit_r && (probe_cmd == lkc_pkg::CMD_INSERT) && !full) begin
      fill_after = fill_level + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lkc_pkg::ST_IDLE;
      fill_level <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        fill_level <= fill_after;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      probe_cmd    <= req.command;
      probe_key    <= req.state_key;
      probe_tag    <= req.pass_tag;
      probe_handle <= req.entry_handle;
    end
    if (state == lkc_pkg::ST_MATCH) begin
      match_r   <= match_vec;
      hit_r     <= |match_vec;
      scan_idx  <= IW'(1);
      victim    <= '0;
      min_count <= counts[0];
    end
    if (state == lkc_pkg::ST_SCAN) begin
      if (counts[scan_idx] < min_count) begin
        min_count <= counts[scan_idx];
        victim    <= scan_idx;
      end
      scan_idx <= scan_idx + IW'(1);
    end
    if (apply_go) begin
      out_hit     <= hit_r;
      out_handle  <= (hit_r && (probe_cmd == lkc_pkg::CMD_LOOKUP)) ? found_handle : '0;
      out_evicted <= do_evict;
      out_occ     <= lkc_pkg::OCC_W'(fill_after);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.found_handle = out_handle;
  assign rsp.evicted      = out_evicted;
  assign rsp.occupancy    = out_occ;

endmodule

// ===== tb/tb_lfu_keyed_cache_table.sv =====
// testbench for the keyed lfu cache table: scoreboard class, request driver and response checker
module tb_lfu_keyed_cache_table;
  import lkc_pkg::*;

  localparam int ENTRIES      = ENTRIES_DEF;
  // narrow counters so saturation is reachable within a short run
  localparam int COUNT_BITS   = 4;
  localparam int POOL         = 12;
  localparam int RANDOM_ITEMS = 1920;
  localparam int SAT_LOOKUPS  = (1 << COUNT_BITS) + 2;
  localparam int LONG_HOLD    = 120;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] found_handle;
    logic             evicted;
    logic [OCC_W-1:0] occupancy;
  } cache_result_t;

  class lfu_scoreboard;
    logic [KEY_W-1:0]      keys    [ENTRIES];
    logic [KEY_W-1:0]      tags    [ENTRIES];
    logic [KEY_W-1:0]      handles [ENTRIES];
    logic [COUNT_BITS-1:0] counts  [ENTRIES];
    int                    fill;
    cache_result_t         pending_results[$];
    int errors, n_requests, n_hits, n_evictions, n_dup_inserts, n_saturated, n_full;

    function new();
      fill = 0;
      errors = 0;
      n_requests = 0;
      n_hits = 0;
      n_evictions = 0;
      n_dup_inserts = 0;
      n_saturated = 0;
      n_full = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // update the table copy for one accepted request and queue its result
    function void note_request(lkc_cmd_t cmd, logic [KEY_W-1:0] key, logic [KEY_W-1:0] tag,
                               logic [KEY_W-1:0] hdl);
      int            idx;
      int            victim;
      cache_result_t r;
      idx = -1;
      r = '0;
      n_requests++;
      for (int i = 0; i < fill; i++)
        if (idx < 0 && keys[i] == key && tags[i] == tag) idx = i;
      if (idx >= 0) begin
        r.hit = 1'b1;
        n_hits++;
        if (cmd == CMD_LOOKUP) begin
          r.found_handle = handles[idx];
          if (counts[idx] != '1) counts[idx]++;
          else n_saturated++;
        end else begin
          n_dup_inserts++;
        end
      end else if (cmd == CMD_INSERT) begin
        if (fill == ENTRIES) begin
          // first entry holding the smallest count goes, the rest close up
          victim = 0;
          for (int i = 1; i < ENTRIES; i++)
            if (counts[i] < counts[victim]) victim = i;
          for (int i = victim; i < ENTRIES - 1; i++) begin
            keys[i]    = keys[i+1];
            tags[i]    = tags[i+1];
            handles[i] = handles[i+1];
            counts[i]  = counts[i+1];
          end
          fill--;
          r.evicted = 1'b1;
          n_evictions++;
        end
        keys[fill]    = key;
        tags[fill]    = tag;
        handles[fill] = hdl;
        counts[fill]  = '0;
        fill++;
        if (fill == ENTRIES) n_full++;
      end
      r.occupancy = OCC_W'(fill);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic hit, logic [KEY_W-1:0] found_handle, logic evicted,
                               logic [OCC_W-1:0] occupancy);
      cache_result_t exp;
      if (pending_results.size() == 0) begin
        $error("response beat with no request outstanding");
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (hit !== exp.hit) begin
        $error("hit: expected %0d, got %0d", exp.hit, hit);
        errors++;
      end
      if (found_handle !== exp.found_handle) begin
        $error("found_handle: expected %08h, got %08h", exp.found_handle, found_handle);
        errors++;
      end
      if (evicted !== exp.evicted) begin
        $error("evicted: expected %0d, got %0d", exp.evicted, evicted);
        errors++;
      end
      if (occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp.occupancy, occupancy);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_idle_on;
  logic rsp_stall_on;
  logic hold_long;
  logic [KEY_W-1:0] pool_key [POOL];
  logic [KEY_W-1:0] pool_tag [POOL];
  int   quiet_cycles;
  lfu_scoreboard sb = new();

  lkc_req_if req ();
  lkc_rsp_if rsp ();

  lfu_keyed_cache_table #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one request beat; returns at the edge that accepted it
  task automatic send_item(lkc_cmd_t cmd, logic [KEY_W-1:0] key, logic [KEY_W-1:0] tag,
                           logic [KEY_W-1:0] hdl);
    req.valid        <= 1'b1;
    req.command      <= cmd;
    req.state_key    <= key;
    req.pass_tag     <= tag;
    req.entry_handle <= hdl;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    sb.note_request(cmd, key, tag, hdl);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // response side: random stall bursts, plus one long hold on request
  initial begin
    rsp.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1)
      sb.check_result(rsp.hit, rsp.found_handle, rsp.evicted, rsp.occupancy);
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin
    int sel;
    int p;
    int j;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.command      = CMD_LOOKUP;
    req.state_key    = '0;
    req.pass_tag     = '0;
    req.entry_handle = '0;
    req_idle_on      = 1'b0;
    rsp_stall_on     = 1'b0;
    hold_long        = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, key extremes, same key with other tag, duplicates, ties
    send_item(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678);
    send_item(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8765_4321);
    send_item(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 32'hDEAD_BEEF);
    send_item(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_5555);
    send_item(CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_AAAA);
    send_item(CMD_INSERT, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001);
    send_item(CMD_INSERT, 32'h0000_0001, 32'h8000_0000, 32'h0000_8000);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(CMD_LOOKUP, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000);
    send_item(CMD_INSERT, 32'h1357_9BDF, 32'h2468_ACE0, 32'h0F0F_0F0F);
    send_item(CMD_INSERT, 32'hFEDC_BA98, 32'h7654_3210, 32'hF0F0_F0F0);
    send_item(CMD_LOOKUP, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000);
    send_item(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_item(CMD_LOOKUP, 32'hFEDC_BA98, 32'h7654_3210, 32'h0000_0000);
    wait_drained();

    // drive one counter into saturation, then evict around it
    send_item(CMD_INSERT, 32'h8000_0001, 32'h7FFF_FFFE, 32'hC001_D00D);
    for (int n = 0; n < SAT_LOOKUPS; n++)
      send_item(CMD_LOOKUP, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0000);
    send_item(CMD_INSERT, 32'h0BAD_F00D, 32'h0000_0000, 32'h1111_1111);
    send_item(CMD_INSERT, 32'h0BAD_F00D, 32'hFFFF_FFFF, 32'h2222_2222);
    send_item(CMD_LOOKUP, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0000);
    wait_drained();

    // random: skewed picks from a small pair pool keep hits and evictions frequent
    req_idle_on  = 1'b1;
    rsp_stall_on = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 160 == 0) begin
        if (n != 0) wait_drained();
        for (int q = 0; q < POOL; q++) begin
          pool_key[q] = $urandom;
          pool_tag[q] = $urandom;
          // some pairs share one key or one tag with an earlier pair
          if (q > 0 && $urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, q - 1);
            pool_key[q] = pool_key[j];
          end else if (q > 0 && $urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, q - 1);
            pool_tag[q] = pool_tag[j];
          end
        end
      end
      if (n == 400) begin
        hold_long   = 1'b1;
        req_idle_on = 1'b0;
      end
      if (n == 440) req_idle_on = 1'b1;
      if (n == RANDOM_ITEMS - 250) begin
        req_idle_on  = 1'b0;
        rsp_stall_on = 1'b0;
      end
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send_item(lkc_cmd_t'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
      end else begin
        p = $urandom_range(0, $urandom_range(0, POOL - 1));
        send_item(($urandom_range(0, 99) < 35) ? CMD_INSERT : CMD_LOOKUP,
                  pool_key[p], pool_tag[p], $urandom);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d requests: %0d hits, %0d duplicate inserts, %0d evictions",
             sb.n_requests, sb.n_hits, sb.n_dup_inserts, sb.n_evictions);
    $display("table filled %0d times, %0d lookups hit a saturated counter",
             sb.n_full, sb.n_saturated);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lkc_pkg.sv
hw/rtl/lkc_if.sv
hw/rtl/lkc_cell.sv
hw/rtl/lfu_keyed_cache_table.sv
tb/tb_lfu_keyed_cache_table.sv
